[rtl/alt_pkg.sv]
// alt_pkg: types and constants shared by the argument tokenizer modules
// payload structs of both queue sides, byte classes, result kinds, error codes
package alt_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_item_t;

  typedef enum logic [2:0] {
    KIND_STR_BYTE = 3'd0,
    KIND_STR_DONE = 3'd1,
    KIND_NUM_BYTE = 3'd2,
    KIND_INT_DONE = 3'd3,
    KIND_FLT_DONE = 3'd4,
    KIND_ERROR    = 3'd5,
    KIND_END      = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ERR_BAD_START  = 3'd0,
    ERR_BAD_AFTER  = 3'd1,
    ERR_UNTERM     = 3'd2,
    ERR_TOO_LONG   = 3'd3,
    ERR_TOO_MANY   = 3'd4
  } err_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         out_byte;
    logic signed [31:0] int_value;
    logic [7:0]         arg_index;
    err_t               error_code;
    logic [8:0]         arg_count;
    logic               last;
  } result_t;

  typedef enum logic [1:0] {
    PH_NEW = 2'd0,
    PH_NUM = 2'd1,
    PH_STR = 2'd2,
    PH_ERR = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    SCAN_SIGN  = 2'd0,
    SCAN_DIGIT = 2'd1,
    SCAN_DONE  = 2'd2
  } scan_t;

  // byte classes worked out by the front end
  typedef struct packed {
    logic sep;
    logic quote;
    logic bslash;
    logic digit;
    logic sign;
    logic minus;
    logic dot;
    logic expo;
    logic comma;
  } cls_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
    cls_t       cls;
  } tok_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

endpackage

[rtl/alt_front.sv]
// alt_front: input side, classifies each byte and holds it in a two-entry queue
// depends on alt_pkg
module alt_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  alt_pkg::in_item_t item,
  input  logic             tok_pop,
  output logic             tok_empty,
  output alt_pkg::tok_t    tok
);
  import alt_pkg::*;

  tok_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  tok_t       cls_item;
  logic       wr;
  logic       rd;

  always_comb begin
    cls_item.data_byte   = item.data_byte;
    cls_item.end_of_data = item.end_of_data;
    cls_item.cls.sep     = (item.data_byte == 8'h00) || (item.data_byte == CH_SPACE);
    cls_item.cls.quote   = (item.data_byte == CH_QUOTE);
    cls_item.cls.bslash  = (item.data_byte == CH_BSLASH);
    cls_item.cls.digit   = (item.data_byte >= CH_ZERO) && (item.data_byte <= CH_NINE);
    cls_item.cls.sign    = (item.data_byte == CH_PLUS) || (item.data_byte == CH_MINUS);
    cls_item.cls.minus   = (item.data_byte == CH_MINUS);
    cls_item.cls.dot     = (item.data_byte == CH_DOT);
    cls_item.cls.expo    = (item.data_byte == CH_LOW_E) || (item.data_byte == CH_UP_E);
    cls_item.cls.comma   = (item.data_byte == CH_COMMA);
  end

  assign full      = (count == 2'd2);
  assign tok_empty = (count == 2'd0);
  assign tok       = q[rptr];
  assign wr        = push && !full;
  assign rd        = tok_pop && !tok_empty;

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wptr] <= cls_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= ~wptr;
      end
      if (rd) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

[rtl/alt_back.sv]
// alt_back: parser state machine, turns classified bytes into up to two results
// depends on alt_pkg
module alt_back #(
  parameter int MAX_ARGS      = 256,
  parameter int NUMBER_BUFFER = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             tok_empty,
  input  alt_pkg::tok_t    tok,
  output logic             tok_pop,
  input  logic             res_room,
  output logic [1:0]       res_n,
  output alt_pkg::result_t res0,
  output alt_pkg::result_t res1
);
  import alt_pkg::*;

  localparam int CW = ($clog2(MAX_ARGS + 1) > 9) ? $clog2(MAX_ARGS + 1) : 9;
  localparam int LW = $clog2(NUMBER_BUFFER);
  localparam logic [CW-1:0] ARG_LIMIT = CW'(MAX_ARGS);
  localparam logic [LW-1:0] LEN_LIMIT = LW'(NUMBER_BUFFER - 1);

  phase_t        phase, phase_next;
  logic          escape_pending, escape_pending_next;
  logic          float_seen, float_seen_next;
  logic [CW-1:0] arg_counter, arg_counter_next;
  logic [LW-1:0] number_length, number_length_next;
  logic [31:0]   int_acc, int_acc_next;
  logic          int_negative, int_negative_next;
  scan_t         int_scan, int_scan_next;

  logic          take;
  logic          start_ch;
  logic          num_ch;
  logic          too_many;
  logic          too_long;
  logic [CW-1:0] cnt_inc;

  // integer scan applied on top of the current or fresh number state
  logic [31:0]   base_acc;
  logic          base_neg;
  scan_t         base_scan;
  logic [35:0]   prod;
  logic [31:0]   scan_acc;
  logic          scan_neg;
  scan_t         scan_ph;

  result_t       fin_res;
  result_t       end_res;

  assign take     = !tok_empty && res_room;
  assign tok_pop  = take;
  assign start_ch = tok.cls.quote || tok.cls.digit || tok.cls.sign || tok.cls.dot;
  assign num_ch   = tok.cls.digit || tok.cls.sign || tok.cls.dot || tok.cls.expo ||
                    tok.cls.comma;
  assign too_many = (arg_counter >= ARG_LIMIT);
  assign too_long = (number_length >= LEN_LIMIT);
  assign cnt_inc  = arg_counter + CW'(1);

  always_comb begin
    base_acc  = (phase == PH_NEW) ? 32'd0 : int_acc;
    base_neg  = (phase == PH_NEW) ? 1'b0 : int_negative;
    base_scan = (phase == PH_NEW) ? SCAN_SIGN : int_scan;
    prod      = ({4'd0, base_acc} << 3) + ({4'd0, base_acc} << 1) +
                {32'd0, tok.data_byte[3:0]};
    scan_acc  = base_acc;
    scan_neg  = base_neg;
    scan_ph   = SCAN_DONE;
    if (base_scan == SCAN_SIGN && tok.cls.sign) begin
      scan_neg = tok.cls.minus;
      scan_ph  = SCAN_DIGIT;
    end else if (base_scan != SCAN_DONE && tok.cls.digit) begin
      scan_acc = (prod > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : prod[31:0];
      scan_ph  = SCAN_DIGIT;
    end
  end

  // next state
  always_comb begin
    phase_next          = phase;
    escape_pending_next = escape_pending;
    float_seen_next     = float_seen;
    arg_counter_next    = arg_counter;
    number_length_next  = number_length;
    int_acc_next        = int_acc;
    int_negative_next   = int_negative;
    int_scan_next       = int_scan;
    if (take) begin
      if (tok.end_of_data) begin
        phase_next          = PH_NEW;
        escape_pending_next = 1'b0;
        float_seen_next     = 1'b0;
        arg_counter_next    = '0;
        number_length_next  = '0;
        int_acc_next        = 32'd0;
        int_negative_next   = 1'b0;
        int_scan_next       = SCAN_SIGN;
      end else begin
        case (phase)
          PH_NEW: begin
            if (tok.cls.sep) begin
              phase_next = PH_NEW;
            end else if (start_ch) begin
              if (too_many) begin
                phase_next = PH_ERR;
              end else if (tok.cls.quote) begin
                phase_next          = PH_STR;
                escape_pending_next = 1'b0;
              end else begin
                phase_next         = PH_NUM;
                number_length_next = LW'(1);
                float_seen_next    = tok.cls.dot;
                int_acc_next       = scan_acc;
                int_negative_next  = scan_neg;
                int_scan_next      = scan_ph;
              end
            end else begin
              phase_next = PH_ERR;
            end
          end
          PH_NUM: begin
            if (tok.cls.sep) begin
              arg_counter_next = cnt_inc;
              phase_next       = PH_NEW;
            end else if (num_ch) begin
              if (too_long) begin
                phase_next = PH_ERR;
              end else begin
                number_length_next = number_length + LW'(1);
                float_seen_next    = float_seen || tok.cls.dot || tok.cls.expo;
                int_acc_next       = scan_acc;
                int_negative_next  = scan_neg;
                int_scan_next      = scan_ph;
              end
            end else begin
              phase_next = PH_ERR;
            end
          end
          PH_STR: begin
            if (tok.cls.quote && !escape_pending) begin
              arg_counter_next = cnt_inc;
              phase_next       = PH_NEW;
            end else if (tok.cls.bslash && !escape_pending) begin
              escape_pending_next = 1'b1;
            end else begin
              escape_pending_next = 1'b0;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_NEW;
      escape_pending <= 1'b0;
      float_seen     <= 1'b0;
      arg_counter    <= '0;
      number_length  <= '0;
      int_acc        <= 32'd0;
      int_negative   <= 1'b0;
      int_scan       <= SCAN_SIGN;
    end else begin
      phase          <= phase_next;
      escape_pending <= escape_pending_next;
      float_seen     <= float_seen_next;
      arg_counter    <= arg_counter_next;
      number_length  <= number_length_next;
      int_acc        <= int_acc_next;
      int_negative   <= int_negative_next;
      int_scan       <= int_scan_next;
    end
  end

  // results
  always_comb begin
    fin_res           = '0;
    fin_res.arg_index = arg_counter[7:0];
    if (float_seen) begin
      fin_res.kind = KIND_FLT_DONE;
    end else begin
      fin_res.kind = KIND_INT_DONE;
      if (int_negative) begin
        fin_res.int_value = 32'd0 - int_acc;
      end else begin
        fin_res.int_value = int_acc[31] ? POS_MAX : int_acc;
      end
    end
    end_res           = '0;
    end_res.kind      = KIND_END;
    end_res.arg_count = (phase == PH_NUM) ? cnt_inc[8:0] : arg_counter[8:0];
    end_res.last      = 1'b1;
  end

  always_comb begin
    res_n = 2'd0;
    res0  = '0;
    res1  = end_res;
    res0.arg_index = arg_counter[7:0];
    if (take) begin
      if (tok.end_of_data) begin
        case (phase)
          PH_NUM: begin
            res0  = fin_res;
            res_n = 2'd2;
          end
          PH_STR: begin
            res0.kind       = KIND_ERROR;
            res0.error_code = ERR_UNTERM;
            res_n           = 2'd2;
          end
          default: begin
            res0  = end_res;
            res_n = 2'd1;
          end
        endcase
      end else begin
        res_n = 2'd1;
        case (phase)
          PH_NEW: begin
            if (tok.cls.sep || (start_ch && !too_many && tok.cls.quote)) begin
              res_n = 2'd0;
            end else if (start_ch && too_many) begin
              res0.kind       = KIND_ERROR;
              res0.error_code = ERR_TOO_MANY;
            end else if (start_ch) begin
              res0.kind     = KIND_NUM_BYTE;
              res0.out_byte = tok.data_byte;
            end else begin
              res0.kind       = KIND_ERROR;
              res0.error_code = ERR_BAD_START;
            end
          end
          PH_NUM: begin
            if (tok.cls.sep) begin
              res0 = fin_res;
            end else if (num_ch && too_long) begin
              res0.kind       = KIND_ERROR;
              res0.error_code = ERR_TOO_LONG;
            end else if (num_ch) begin
              res0.kind     = KIND_NUM_BYTE;
              res0.out_byte = tok.data_byte;
            end else begin
              res0.kind       = KIND_ERROR;
              res0.error_code = ERR_BAD_AFTER;
            end
          end
          PH_STR: begin
            if (tok.cls.quote && !escape_pending) begin
              res0.kind = KIND_STR_DONE;
            end else if (tok.cls.bslash && !escape_pending) begin
              res_n = 2'd0;
            end else begin
              res0.kind     = KIND_STR_BYTE;
              res0.out_byte = tok.data_byte;
            end
          end
          default: begin
            res_n = 2'd0;
          end
        endcase
      end
    end
    res0.last = (res_n == 2'd1);
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    take && tok.end_of_data |=> phase == PH_NEW && arg_counter == '0)
    else $error("parse state not cleared after end marker");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    arg_counter <= ARG_LIMIT)
    else $error("argument counter beyond limit");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_NUM |-> number_length != '0 && number_length <= LEN_LIMIT)
    else $error("number length out of range inside a number");

  a_two_only_at_end: assert property (@(posedge clk) disable iff (rst)
    res_n == 2'd2 |-> take && tok.end_of_data)
    else $error("two results from a plain byte");

endmodule

[rtl/alt_res_fifo.sv]
// alt_res_fifo: result queue, takes up to two results a cycle, gives one
// depends on alt_pkg
module alt_res_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       wr_n,
  input  alt_pkg::result_t wr0,
  input  alt_pkg::result_t wr1,
  output logic             room,
  input  logic             pop,
  output logic             empty,
  output alt_pkg::result_t result
);
  import alt_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  result_t       mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic          rd;

  assign empty  = (count == '0);
  assign room   = (count <= (AW+1)'(DEPTH - 2));
  assign result = mem[rptr];
  assign rd     = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      mem[wptr] <= wr0;
    end
    if (wr_n == 2'd2) begin
      mem[wptr + AW'(1)] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + AW'(wr_n);
      if (rd) begin
        rptr <= rptr + AW'(1);
      end
      count <= count + (AW+1)'(wr_n) - (AW+1)'(rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("result queue overflow");

  a_write_needs_room: assert property (@(posedge clk) disable iff (rst)
    wr_n != 2'd0 |-> room)
    else $error("result written without room");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    rd && wr_n == 2'd0 |=> count == $past(count) - (AW+1)'(1))
    else $error("count did not follow a lone transfer out");

endmodule

[rtl/argument_list_tokenizer_unit.sv]
// argument list tokenizer: splits a byte stream into string and number arguments
// path: a byte's results are parsed from the front queue and written to the result queue
// throughput: one byte per cycle while the result queue has room; an end marker inside a
// string or number yields two results, which the one-result-per-cycle output side drains
// reset: rst, synchronous, active high, empties both queues and starts a new parse
// depends on alt_pkg, alt_front, alt_back, alt_res_fifo
module argument_list_tokenizer_unit #(
  parameter int MAX_ARGS      = 256,
  parameter int NUMBER_BUFFER = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  alt_pkg::in_item_t item,
  output logic             empty,
  input  logic             pop,
  output alt_pkg::result_t result
);
  import alt_pkg::*;

  logic       tok_pop;
  logic       tok_empty;
  tok_t       tok;
  logic       res_room;
  logic [1:0] res_n;
  result_t    res0;
  result_t    res1;

  alt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .tok_pop   (tok_pop),
    .tok_empty (tok_empty),
    .tok       (tok)
  );

  alt_back #(
    .MAX_ARGS      (MAX_ARGS),
    .NUMBER_BUFFER (NUMBER_BUFFER)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_empty (tok_empty),
    .tok       (tok),
    .tok_pop   (tok_pop),
    .res_room  (res_room),
    .res_n     (res_n),
    .res0      (res0),
    .res1      (res1)
  );

  alt_res_fifo u_res_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_n   (res_n),
    .wr0    (res0),
    .wr1    (res1),
    .room   (res_room),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

endmodule
